FILE: rtl/ibm2ieee_pkg.sv
`default_nettype none
package ibm2ieee_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned FracW = 24;
	localparam int unsigned ExpW = 7;
	localparam int unsigned MsbW = 5;
	localparam int unsigned BiasW = 11;
	localparam logic signed [BiasW-1:0] IeeeBias = 11'sd127;
	localparam logic signed [BiasW-1:0] IbmBias = 11'sd64;
	localparam logic signed [BiasW-1:0] IeeeExpMax = 11'sd255;
	localparam logic [WordW-1:0] InfBits = 32'h7F80_0000;
	localparam logic [WordW-1:0] ZeroBits = 32'h0000_0000;

	typedef struct packed {
		logic sign;
		logic [ExpW-1:0] expo;
		logic [FracW-1:0] frac;
	} ibm_word_t;
endpackage
`default_nettype wire

FILE: rtl/ibm2ieee_core.sv
`default_nettype none
module ibm2ieee_core
	import ibm2ieee_pkg::*;
(
	input  wire ibm_word_t      word,
	output logic [WordW-1:0]    result
);
	logic [MsbW-1:0] msb;
	logic signed [BiasW-1:0] e4;
	logic signed [BiasW-1:0] biased;
	logic signed [BiasW-1:0] sh;
	logic [FracW-1:0] sig;
	logic [FracW-1:0] q;
	logic [FracW-1:0] rem;
	logic [FracW-1:0] half;
	logic [FracW-1:0] mask;
	logic [4:0] s5;
	logic [4:0] l5;
	logic [WordW-1:0] sgn;

	always_comb begin
		msb = '0;
		for (int i = 1; i < FracW; i++) begin
			if (word.frac[i])
				msb = MsbW'(i);
		end
	end

	assign e4 = BiasW'(signed'({1'b0, word.expo})) <<< 2;
	assign biased = BiasW'(signed'({1'b0, msb})) + e4 - (IbmBias <<< 2)
		- 11'sd24 + IeeeBias;
	assign sh = 11'sd131 - e4;
	assign sig = word.frac << (5'd23 - msb);
	assign sgn = {word.sign, 31'd0};
	assign s5 = sh[4:0];
	assign l5 = 5'(-sh);
	assign mask = (FracW'(1) << s5) - FracW'(1);
	assign q = word.frac >> s5;
	assign rem = word.frac & mask;
	assign half = FracW'(1) << (s5 - 5'd1);

	always_comb begin
		if (word.frac == '0)
			result = ZeroBits;
		else if (biased >= IeeeExpMax)
			result = sgn | InfBits;
		else if (biased >= 11'sd1)
			result = sgn | {1'b0, biased[7:0], sig[22:0]};
		else if (sh <= 11'sd0)
			result = sgn | {8'd0, (word.frac << ((l5 > 5'd23) ? 5'd23 : l5))};
		else if (sh >= 11'sd26)
			result = sgn;
		else if (rem > half || (rem == half && q[0]))
			result = sgn | {8'd0, q + FracW'(1)};
		else
			result = sgn | {8'd0, q};
	end
endmodule
`default_nettype wire

FILE: rtl/ibm_float_to_ieee_single_unit.sv
// IBM hex float to IEEE single converter.
// Input: raise start with ibm_word; the beat is taken on any edge where busy
// is low. busy is tied low, so a word can be given every cycle.
// Output: ieee_word appears with done high for exactly one cycle.
// Path: the accepted word passes the input register, then the result
// register. Throughput: one word per cycle, set by the single conversion
// stage between the two registers.
// Zero fraction gives +0; overflow gives signed infinity; tiny values become
// subnormal or signed zero, rounded to nearest even.
// The receiver cannot stall: each result must be taken in its done cycle.
// Reset (arst_n low) clears the valid flags; words in flight are dropped.
`default_nettype none
module ibm_float_to_ieee_single_unit
	import ibm2ieee_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  wire [WordW-1:0]  ibm_word,
	output logic             done,
	output logic [WordW-1:0] ieee_word
);
	logic v_s1;
	ibm_word_t w_s1;
	logic [WordW-1:0] r;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= ibm_word_t'(ibm_word);
		ieee_word <= r;
	end

	ibm2ieee_core u_core (.word(w_s1), .result(r));

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> ##1 done) else $error("result lost");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> ##1 !done) else $error("spurious result");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && w_s1.frac == '0) |=> ieee_word == ZeroBits)
		else $error("zero fraction not +0");
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
module tb_top
	import ibm2ieee_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	class conv_scoreboard;
		logic [WordW-1:0] pending_q[$];
		int n_errors;
		int n_checked;

		function logic [WordW-1:0] ibm_to_ieee(logic [WordW-1:0] w);
			logic sgn;
			int e;
			logic [FracW-1:0] frac;
			int msb;
			int biased;
			int s;
			logic [31:0] q;
			logic [31:0] rem;
			logic [31:0] half;
			sgn = w[31];
			e = w[30:24];
			frac = w[23:0];
			if (frac == 0) return ZeroBits;
			msb = 0;
			for (int i = 23; i > 0; i--) begin
				if (frac[i]) begin
					msb = i;
					break;
				end
			end
			biased = msb + 4 * (e - 64 - 6) + 127;
			if (biased >= 255) return {sgn, 31'h7F80_0000};
			if (biased >= 1)
				return {sgn, biased[7:0], 23'((frac << (23 - msb)) & 24'h7F_FFFF)};
			s = 131 - 4 * e;
			if (s <= 0) begin
				int l;
				l = -s;
				if (l > 23) l = 23;
				return {sgn, 31'((32'(frac) << l) & 32'h00FF_FFFF)};
			end
			if (s >= 26) return {sgn, 31'd0};
			q = 32'(frac) >> s;
			rem = 32'(frac) & ((32'd1 << s) - 1);
			half = 32'd1 << (s - 1);
			if (rem > half || (rem == half && q[0])) q++;
			return {sgn, q[30:0]};
		endfunction

		function void note_word(logic [WordW-1:0] w);
			pending_q.push_back(ibm_to_ieee(w));
		endfunction

		function void check_result(logic [WordW-1:0] got);
			logic [WordW-1:0] want;
			if (pending_q.size() == 0) begin
				$error("ieee_word: unexpected result %h", got);
				n_errors++;
				return;
			end
			want = pending_q.pop_front();
			n_checked++;
			if (got !== want) begin
				$error("ieee_word: expected %h, actual %h", want, got);
				n_errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [WordW-1:0] ibm_word = '0;
	logic busy;
	logic done;
	logic [WordW-1:0] ieee_word;
	conv_scoreboard sb = new();
	int n_words;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ibm_float_to_ieee_single_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ibm_word(ibm_word), .done(done), .ieee_word(ieee_word)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_word(ibm_word);
			if (done) sb.check_result(ieee_word);
		end
	end

	// hold start across consecutive beats; drop it only on a gap
	task automatic send_word(logic [WordW-1:0] w, bit allow_gap);
		int gap;
		start <= 1'b1;
		ibm_word <= w;
		do @(posedge clk); while (busy);
		n_words++;
		if (allow_gap && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			ibm_word <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [WordW-1:0] rand_word();
		logic [WordW-1:0] w;
		logic [6:0] e;
		w = $urandom;
		case ($urandom_range(0, 7))
			0: e = 7'($urandom_range(0, 6));
			1: e = 7'($urandom_range(26, 36));
			2: e = 7'($urandom_range(90, 127));
			default: e = 7'($urandom);
		endcase
		w[30:24] = e;
		case ($urandom_range(0, 5))
			0: w[23:0] = 24'd1 << $urandom_range(0, 23);
			1: w[23:0] = w[23:0] >> $urandom_range(0, 23);
			2: w[23:0] = '0;
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		logic [WordW-1:0] directed[$];
		directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F00_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h4110_0000, 32'hC110_0000, 32'h6080_0000,
			32'h6100_0001, 32'h0000_0001, 32'h0080_0000, 32'h8080_0000,
			32'h2180_0000, 32'h2100_0001, 32'h2100_0002, 32'h2100_0003,
			32'h2200_0001, 32'h2300_0003, 32'h20FF_FFFF, 32'h210F_FFFF,
			32'h1FFF_FFFF, 32'h2100_0008, 32'h00FF_FFFF, 32'h4000_0001,
			32'h60FF_FFFF};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_word(directed[i], 1'b1);
		for (int i = 0; i < 900; i++) begin
			send_word(rand_word(), 1'b1);
			if (i == 450) drain();
		end
		for (int i = 0; i < 200; i++) send_word(rand_word(), 1'b0);
		drain();
		repeat (5) @(posedge clk);
		$display("Converted %0d words, %0d results checked, incl. zero, subnormal, overflow.",
			n_words, sb.n_checked);
		if (sb.n_errors == 0 && sb.pending_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#200us;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
